// ----- rtl/core/bipw_pkg.sv -----
// Shared types and constants for the bank-interleaved pixel writer.
// No dependencies; imported by bipw_merge, the top level and the testbench.
package bipw_pkg;

	// video memory geometry
	localparam int MEM_BYTES     = 16384;
	localparam int BANK_OFFSET   = 8192;
	localparam int BYTES_PER_ROW = 80;
	localparam int SCREEN_ROWS   = 200;
	localparam int WIDTH_2BPP    = 320;
	localparam int WIDTH_1BPP    = 640;
	localparam int ADDR_W        = $clog2(MEM_BYTES);

	// command codes
	localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
	localparam logic [1:0] CMD_FILL      = 2'd1;
	localparam logic [1:0] CMD_CLEAR     = 2'd2;
	localparam logic [1:0] CMD_READ      = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_NOT_ENABLED = 2'd1;
	localparam logic [1:0] STATUS_OFF_SCREEN  = 2'd2;

	// configuration register indexes
	localparam logic REG_GRAPHICS_MODE = 1'b0;
	localparam logic REG_ENABLED       = 1'b1;

	// control for the byte merge: which pixels of the byte are touched
	typedef struct packed {
		logic       mode;   // 1 = one bit per pixel
		logic       first;  // byte holds the left edge of the span
		logic       last;   // byte holds the right edge of the span
		logic [2:0] lo;     // first pixel within the byte on the left edge
		logic [2:0] hi;     // last pixel within the byte on the right edge
	} merge_ctl_t;

endpackage

// ----- rtl/core/bipw_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bipw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bipw_merge.sv -----
// Byte merge for read-modify-write: replaces the pixels of one video byte
// that fall inside the current span. Depends on bipw_pkg.
module bipw_merge
	import bipw_pkg::*;
(
	input  merge_ctl_t ctl,
	input  logic [7:0] old_byte,
	input  logic [7:0] pattern,
	output logic [7:0] new_byte
);

	logic [2:0] lo_eff;
	logic [2:0] hi_eff;
	logic [7:0] mask;

	// pixel range inside this byte
	assign lo_eff = ctl.first ? ctl.lo : 3'd0;
	assign hi_eff = ctl.last ? ctl.hi : (ctl.mode ? 3'd7 : 3'd3);

	// bit mask, leftmost pixel in the high bits
	always_comb begin
		logic [2:0] pix;
		for (int i = 0; i < 8; i++) begin
			if (ctl.mode) begin
				pix = 3'(7 - i);
			end else begin
				pix = 3'(3 - (i / 2));
			end
			mask[i] = (pix >= lo_eff) && (pix <= hi_eff);
		end
	end

	assign new_byte = (old_byte & ~mask) | (pattern & mask);

endmodule

// ----- rtl/core/bank_interleaved_pixel_writer.sv -----
// Bank-interleaved pixel writer top level: command sequencer around the
// 16 KB video memory. Depends on bipw_pkg, bipw_ram and bipw_merge.
//
// Usage: a request is taken at a clock edge with start high and busy low.
// Each request gives exactly one result, shown for one cycle with done high
// on status and read_byte; the receiver cannot hold it off.
// Configuration (graphics_mode, enabled) is written through cfg_we,
// cfg_index and cfg_wdata; the user writes it only while the block is idle,
// as the block itself does not enforce it. Steps per request:
//   read byte: one RAM read at byte_address, captured in state S_RDB.
//   rejected or empty drawing requests: result from the idle state.
//   set pixel, fill and clear: every video byte touched is read in state
//   S_RD and written back in state S_WR over the single read and single
//   write port of the video memory.
// busy is high while a request is in the memory sequencer; a new request
// may be given in the cycle its predecessor's result is shown.
// Reset clears the mode to 320x200, disables drawing and idles the block;
// video memory content is undefined until written.
module bank_interleaved_pixel_writer
	import bipw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic               cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [10:0] x_or_left,
	input  logic signed [10:0] y_or_top,
	input  logic signed [10:0] right_edge,
	input  logic signed [10:0] bottom_edge,
	input  logic [1:0]         color_index,
	input  logic [13:0]        byte_address,
	output logic               done,
	output logic [1:0]         status,
	output logic [7:0]         read_byte
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WR   = 2'd2;
	localparam logic [1:0] S_RDB  = 2'd3;

	logic [1:0]        state_q;
	logic              mode_q;
	logic              enabled_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [7:0]        read_byte_q;
	logic [6:0]        cx_q, c0_q, c1_q;
	logic [7:0]        cy_q, ylast_q;
	logic [2:0]        lo_q, hi_q;
	logic [7:0]        pat_q;

	logic              accept;
	logic signed [10:0] scr_w;
	logic signed [10:0] x0_c, x1_c, y0_c, y1_c, xl_c, yl_c;
	logic              off_screen;
	logic              empty;
	logic [6:0]        half_row;
	logic [ADDR_W-1:0] fill_addr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;
	logic [7:0]        new_byte;
	logic              wr_en;
	merge_ctl_t        mctl;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAPHICS_MODE: mode_q    <= cfg_wdata;
				REG_ENABLED:       enabled_q <= cfg_wdata;
			endcase
		end
	end

	// span of the request: fill clipped to the screen, set pixel as given, clear the whole screen
	assign scr_w = mode_q ? 11'(WIDTH_1BPP) : 11'(WIDTH_2BPP);

	always_comb begin
		x0_c = '0;
		x1_c = scr_w;
		y0_c = '0;
		y1_c = 11'(SCREEN_ROWS);
		if (cmd == CMD_SET_PIXEL) begin
			x0_c = x_or_left;
			x1_c = x_or_left + 11'sd1;
			y0_c = y_or_top;
			y1_c = y_or_top + 11'sd1;
		end else if (cmd == CMD_FILL) begin
			if (x_or_left > x0_c) begin
				x0_c = x_or_left;
			end
			if (y_or_top > y0_c) begin
				y0_c = y_or_top;
			end
			if (right_edge < x1_c) begin
				x1_c = right_edge;
			end
			if (bottom_edge < y1_c) begin
				y1_c = bottom_edge;
			end
		end
	end

	assign xl_c = x1_c - 11'sd1;
	assign yl_c = y1_c - 11'sd1;
	assign off_screen = (x_or_left < 11'sd0) || (x_or_left >= scr_w) ||
		(y_or_top < 11'sd0) || (y_or_top >= 11'(SCREEN_ROWS));
	assign empty = (x0_c >= x1_c) || (y0_c >= y1_c);

	// byte address of the current column and row
	assign half_row  = cy_q[7:1];
	assign fill_addr = (cy_q[0] ? ADDR_W'(BANK_OFFSET) : '0) +
		ADDR_W'(half_row) * ADDR_W'(BYTES_PER_ROW) + ADDR_W'(cx_q);

	assign raddr = (state_q == S_IDLE) ? byte_address : fill_addr;
	assign wr_en = (state_q == S_WR);

	assign mctl.mode  = mode_q;
	assign mctl.first = (cx_q == c0_q);
	assign mctl.last  = (cx_q == c1_q);
	assign mctl.lo    = lo_q;
	assign mctl.hi    = hi_q;

	bipw_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_vram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(fill_addr),
		.wdata(new_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	bipw_merge u_merge (
		.ctl     (mctl),
		.old_byte(rdata),
		.pattern (pat_q),
		.new_byte(new_byte)
	);

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_READ) begin
							state_q <= S_RDB;
						end else if (!enabled_q || (cmd == CMD_SET_PIXEL && off_screen) ||
							empty) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (cx_q == c1_q && cy_q == ylast_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RDB: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	// span counters and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cx_q    <= mode_q ? 7'(x0_c[9:3]) : 7'(x0_c[9:2]);
			c0_q    <= mode_q ? 7'(x0_c[9:3]) : 7'(x0_c[9:2]);
			c1_q    <= mode_q ? 7'(xl_c[9:3]) : 7'(xl_c[9:2]);
			lo_q    <= mode_q ? x0_c[2:0] : {1'b0, x0_c[1:0]};
			hi_q    <= mode_q ? xl_c[2:0] : {1'b0, xl_c[1:0]};
			cy_q    <= y0_c[7:0];
			ylast_q <= yl_c[7:0];
			pat_q   <= mode_q ? {8{|color_index}} : {4{color_index}};
			read_byte_q <= 8'd0;
			if (cmd == CMD_READ) begin
				status_q <= STATUS_OK;
			end else if (!enabled_q) begin
				status_q <= STATUS_NOT_ENABLED;
			end else if (cmd == CMD_SET_PIXEL && off_screen) begin
				status_q <= STATUS_OFF_SCREEN;
			end else begin
				status_q <= STATUS_OK;
			end
		end else if (state_q == S_WR) begin
			if (cx_q == c1_q) begin
				cx_q <= c0_q;
				cy_q <= cy_q + 8'd1;
			end else begin
				cx_q <= cx_q + 7'd1;
			end
		end else if (state_q == S_RDB) begin
			read_byte_q <= rdata;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_byte = read_byte_q;

	// a read request gives its result from state S_RDB
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_READ |=> ##1 done)
		else $error("read result not on time");

	// column walk stays inside the span
	a_col_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> cx_q <= c1_q && cy_q <= ylast_q)
		else $error("fill walk left its span");

	// every memory write is preceded by its read
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_RD)
		else $error("write without read");

	// rejected requests return no data
	a_read_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STATUS_OK |-> read_byte == 8'd0)
		else $error("rejected request returned data");

	// the read state always goes on to its write state, with no result shown there
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> state_q == S_WR && !done)
		else $error("sequencer skipped its write");

endmodule

// ----- verif/bank_interleaved_pixel_writer_test.sv -----
// Self-checking testbench for bank_interleaved_pixel_writer: a directed table, then random phases.
// Keeps its own copy of video memory to predict every result.
// Depends on bipw_pkg and the bank_interleaved_pixel_writer RTL.
module bank_interleaved_pixel_writer_test;
	import bipw_pkg::*;

	localparam int  PHASES          = 8;
	localparam int  ITEMS_PER_PHASE = 125;
	localparam int  SETTLE_CYCLES   = 4;
	localparam int  STALL_LIMIT     = 150000;
	localparam logic PREDICT        = 1'b0;
	localparam logic FIXED          = 1'b1;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
	} outcome_t;

	typedef struct packed {
		logic               is_cfg;
		logic               reg_index;
		logic               reg_value;
		logic [1:0]         op;
		logic signed [10:0] xl;
		logic signed [10:0] yt;
		logic signed [10:0] re;
		logic signed [10:0] be;
		logic [1:0]         color;
		logic [13:0]        addr;
		logic               fixed;
		outcome_t           want;
	} step_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic               cfg_wdata;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [10:0] x_or_left;
	logic signed [10:0] y_or_top;
	logic signed [10:0] right_edge;
	logic signed [10:0] bottom_edge;
	logic [1:0]         color_index;
	logic [13:0]        byte_address;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         read_byte;

	// predicted video memory and register copies
	logic [7:0] video_copy [MEM_BYTES];
	logic       pred_mode;
	logic       pred_enabled;

	outcome_t   pending_results[$];
	logic       cur_fixed;
	outcome_t   cur_want;
	int         errors = 0;
	int         idle_cycles = 0;
	int         n_results = 0;
	int         n_reg_writes = 0;
	int         n_ops [4] = '{0, 0, 0, 0};

	bank_interleaved_pixel_writer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.x_or_left(x_or_left),
		.y_or_top(y_or_top),
		.right_edge(right_edge),
		.bottom_edge(bottom_edge),
		.color_index(color_index),
		.byte_address(byte_address),
		.done(done),
		.status(status),
		.read_byte(read_byte)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// read-modify-write of the byte holding one on-screen pixel
	function automatic void plot_pixel(int x, int y, logic [1:0] color);
		int addr;
		int sh;
		addr = (y & 1) * BANK_OFFSET + (y >> 1) * BYTES_PER_ROW;
		if (pred_mode) begin
			addr = addr + (x >> 3);
			sh = 7 - (x & 7);
			video_copy[addr][sh] = (color != 2'd0);
		end else begin
			addr = addr + (x >> 2);
			sh = (3 - (x & 3)) * 2;
			video_copy[addr][sh +: 2] = color;
		end
	endfunction

	// applies one request to the memory copy and returns its result
	function automatic outcome_t predict_request(logic [1:0] op, int xl, int yt, int re, int be,
		logic [1:0] color, logic [13:0] addr);
		outcome_t r;
		int w, x0, y0, x1, y1, x, y;
		r = '0;
		w = pred_mode ? WIDTH_1BPP : WIDTH_2BPP;
		if (op == CMD_READ) begin
			r.data = video_copy[addr];
		end else if (!pred_enabled) begin
			r.status = STATUS_NOT_ENABLED;
		end else if (op == CMD_SET_PIXEL) begin
			if (xl < 0 || xl >= w || yt < 0 || yt >= SCREEN_ROWS)
				r.status = STATUS_OFF_SCREEN;
			else
				plot_pixel(xl, yt, color);
		end else begin
			x0 = 0;
			y0 = 0;
			x1 = w;
			y1 = SCREEN_ROWS;
			// fill is clipped to the screen, clear takes it whole
			if (op == CMD_FILL) begin
				if (xl > x0) x0 = xl;
				if (yt > y0) y0 = yt;
				if (re < x1) x1 = re;
				if (be < y1) y1 = be;
			end
			for (y = y0; y < y1; y++)
				for (x = x0; x < x1; x++)
					plot_pixel(x, y, color);
		end
		return r;
	endfunction

	function automatic step_t reg_write(logic idx, logic val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_index = idx;
		s.reg_value = val;
		return s;
	endfunction

	function automatic step_t request(logic [1:0] op, int xl, int yt, int re, int be,
		logic [1:0] color, int addr, logic fixed = PREDICT,
		logic [1:0] st = STATUS_OK, logic [7:0] data = 8'h00);
		step_t s;
		s = '0;
		s.op = op;
		s.xl = 11'(xl);
		s.yt = 11'(yt);
		s.re = 11'(re);
		s.be = 11'(be);
		s.color = color;
		s.addr = 14'(addr);
		s.fixed = fixed;
		s.want.status = st;
		s.want.data = data;
		return s;
	endfunction

	// mostly on-screen pixels, small fills near the screen and reads of pixel bytes
	function automatic step_t random_step();
		step_t s;
		int pick, w, x0, y0;
		s = '0;
		s.xl = 11'($urandom);
		s.yt = 11'($urandom);
		s.re = 11'($urandom);
		s.be = 11'($urandom);
		s.color = 2'($urandom);
		s.addr = 14'($urandom);
		w = pred_mode ? WIDTH_1BPP : WIDTH_2BPP;
		pick = $urandom_range(0, 999);
		if (pick < 400) begin
			s.op = CMD_SET_PIXEL;
			if ($urandom_range(0, 9) != 0) begin
				s.xl = 11'($urandom_range(0, w - 1));
				s.yt = 11'($urandom_range(0, SCREEN_ROWS - 1));
			end
		end else if (pick < 640) begin
			s.op = CMD_FILL;
			if ($urandom_range(0, 24) != 0) begin
				x0 = int'($urandom_range(0, w + 15)) - 8;
				y0 = int'($urandom_range(0, SCREEN_ROWS + 7)) - 4;
				s.xl = 11'(x0);
				s.yt = 11'(y0);
				s.re = 11'(x0 + int'($urandom_range(0, 52)) - 4);
				s.be = 11'(y0 + int'($urandom_range(0, 12)) - 2);
			end
		end else if (pick < 997) begin
			// padding bytes at the end of each bank are never written, so never read
			s.op = CMD_READ;
			s.addr = 14'($urandom_range(0, 1) * BANK_OFFSET
				+ $urandom_range(0, (SCREEN_ROWS / 2) * BYTES_PER_ROW - 1));
		end else begin
			s.op = CMD_CLEAR;
		end
		return s;
	endfunction

	// observe register writes, check results, predict each accepted request
	always @(posedge clk) begin : observe
		outcome_t exp_o;
		logic active;
		active = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_ENABLED)
					pred_enabled = cfg_wdata;
				else
					pred_mode = cfg_wdata;
				n_reg_writes++;
			end
			if (done) begin
				active = 1'b1;
				if (pending_results.size() == 0) begin
					errors++;
					$error("result with no request outstanding: status %0d read_byte 0x%02h",
						status, read_byte);
				end else begin
					exp_o = pending_results.pop_front();
					if (exp_o.status !== status) begin
						errors++;
						$error("status: expected %0d, got %0d", exp_o.status, status);
					end
					if (exp_o.data !== read_byte) begin
						errors++;
						$error("read_byte: expected 0x%02h, got 0x%02h", exp_o.data, read_byte);
					end
					n_results++;
				end
			end
			if (start && !busy) begin
				active = 1'b1;
				exp_o = predict_request(cmd, x_or_left, y_or_top, right_edge, bottom_edge,
					color_index, byte_address);
				if (cur_fixed)
					exp_o = cur_want;
				pending_results.push_back(exp_o);
				n_ops[cmd]++;
			end
		end
		idle_cycles = active ? 0 : idle_cycles + 1;
	end

	// watchdog on cycles with neither a request nor a result
	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// present one request at a falling edge and hold it until taken
	task automatic issue(step_t s);
		cmd = s.op;
		x_or_left = s.xl;
		y_or_top = s.yt;
		right_edge = s.re;
		bottom_edge = s.be;
		color_index = s.color;
		byte_address = s.addr;
		cur_fixed = s.fixed;
		cur_want = s.want;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic hold_off(int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// wait for every outstanding result, then let the block settle
	task automatic drain_results();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply(step_t s);
		if (s.is_cfg) begin
			drain_results();
			cfg_we = 1'b1;
			cfg_index = s.reg_index;
			cfg_wdata = s.reg_value;
			@(negedge clk);
			cfg_we = 1'b0;
		end else begin
			issue(s);
		end
	endtask

	initial begin : stimulus
		step_t script[$];
		int phase, k, idle_pct;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRAPHICS_MODE;
		cfg_wdata = 1'b0;
		start = 1'b0;
		cmd = CMD_SET_PIXEL;
		x_or_left = '0;
		y_or_top = '0;
		right_edge = '0;
		bottom_edge = '0;
		color_index = '0;
		byte_address = '0;
		cur_fixed = PREDICT;
		cur_want = '0;
		pred_mode = 1'b0;
		pred_enabled = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: drawing rejected after reset, then both modes and edge cases
		script.push_back(request(CMD_SET_PIXEL, 5, 5, 0, 0, 2'd3, 0, FIXED, STATUS_NOT_ENABLED));
		script.push_back(request(CMD_FILL, -1024, -1024, 1023, 1023, 2'd1, 0, FIXED,
			STATUS_NOT_ENABLED));
		script.push_back(request(CMD_CLEAR, 0, 0, 0, 0, 2'd2, 0, FIXED, STATUS_NOT_ENABLED));
		script.push_back(reg_write(REG_ENABLED, 1'b1));
		script.push_back(request(CMD_CLEAR, 0, 0, 0, 0, 2'd0, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 0, FIXED, STATUS_OK, 8'h00));
		script.push_back(request(CMD_SET_PIXEL, 0, 0, 0, 0, 2'd3, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 0, FIXED, STATUS_OK, 8'hC0));
		script.push_back(request(CMD_SET_PIXEL, 319, 199, 0, 0, 2'd2, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 16191, FIXED, STATUS_OK, 8'h02));
		script.push_back(request(CMD_SET_PIXEL, 320, 0, 0, 0, 2'd1, 0, FIXED,
			STATUS_OFF_SCREEN));
		script.push_back(request(CMD_SET_PIXEL, -1, 0, 0, 0, 2'd1, 0, FIXED, STATUS_OFF_SCREEN));
		script.push_back(request(CMD_SET_PIXEL, 0, 200, 0, 0, 2'd1, 0, FIXED,
			STATUS_OFF_SCREEN));
		script.push_back(request(CMD_SET_PIXEL, -1024, 1023, 0, 0, 2'd1, 0, FIXED,
			STATUS_OFF_SCREEN));
		// inverted rectangle writes nothing
		script.push_back(request(CMD_FILL, 50, 30, 10, 40, 2'd3, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_FILL, -1024, -1024, 1023, 1023, 2'd1, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 100, FIXED, STATUS_OK, 8'h55));
		script.push_back(request(CMD_FILL, 3, 1, 9, 4, 2'd2, 0));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 8192));
		script.push_back(reg_write(REG_GRAPHICS_MODE, 1'b1));
		script.push_back(request(CMD_SET_PIXEL, 639, 199, 0, 0, 2'd0, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 16191, FIXED, STATUS_OK, 8'h54));
		script.push_back(request(CMD_SET_PIXEL, 640, 0, 0, 0, 2'd1, 0, FIXED,
			STATUS_OFF_SCREEN));
		script.push_back(request(CMD_SET_PIXEL, 7, 2, 0, 0, 2'd2, 0));
		script.push_back(request(CMD_CLEAR, 0, 0, 0, 0, 2'd2, 0, FIXED, STATUS_OK));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 7999, FIXED, STATUS_OK, 8'hFF));
		// reads still work while drawing is disabled
		script.push_back(reg_write(REG_ENABLED, 1'b0));
		script.push_back(request(CMD_READ, 0, 0, 0, 0, 2'd0, 0, FIXED, STATUS_OK, 8'hFF));
		script.push_back(request(CMD_SET_PIXEL, 1, 1, 0, 0, 2'd1, 0, FIXED,
			STATUS_NOT_ENABLED));
		foreach (script[i])
			apply(script[i]);

		// random phases, each with its own register setting and idling
		for (phase = 0; phase < PHASES; phase++) begin
			apply(reg_write(REG_GRAPHICS_MODE,
				(phase < 2) ? phase[0] : 1'($urandom_range(0, 1))));
			apply(reg_write(REG_ENABLED, (phase < 2) || ($urandom_range(0, 4) != 0)));
			idle_pct = (phase == 2 || phase == PHASES - 1) ? 0 :
				($urandom_range(0, 1) ? 20 : 45);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (idle_pct != 0 && $urandom_range(0, 59) == 0)
					drain_results();
				else if ($urandom_range(0, 99) < idle_pct)
					hold_off($urandom_range(1, 13));
				issue(random_step());
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		$display("covered %0d set pixel, %0d fill, %0d clear and %0d read requests",
			n_ops[CMD_SET_PIXEL], n_ops[CMD_FILL], n_ops[CMD_CLEAR], n_ops[CMD_READ]);
		$display("over %0d register writes in both modes; %0d results checked, %0d mismatches",
			n_reg_writes, n_results, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
